// ===== sv/hec_pkg.sv =====
// Shared types, constants and helper functions for the Hamming byte coder.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package hec_pkg;

  localparam int BYTE_W         = 8;   // width of a data byte
  localparam int CODE_W         = 12;  // codeword positions carried on the ports
  localparam int LEN_W          = 4;   // width of a codeword length
  localparam int SYN_W          = 4;   // syndrome width, also most parity bits in use
  localparam int PCNT_W         = 3;   // width of the parity bit count
  localparam int DATA_BITS_DEF  = 8;   // default data bits taken from a byte

  typedef enum logic {
    OP_ENCODE = 1'b0,
    OP_CHECK  = 1'b1
  } opcode_t;

  typedef enum logic {
    PAR_ODD  = 1'b0,
    PAR_EVEN = 1'b1
  } parity_mode_t;

  typedef struct packed {
    logic [CODE_W-1:0] codeword;
    logic [LEN_W-1:0]  code_length;
    logic [PCNT_W-1:0] parity_count;
    logic              error_found;
    logic [SYN_W-1:0]  error_position;
    logic [BYTE_W-1:0] data;
  } result_t;

  // One-based codeword position of data bit j: the positions that are not powers of two.
  localparam logic [LEN_W-1:0] DATA_POS [BYTE_W] = '{
    4'd3, 4'd5, 4'd6, 4'd7, 4'd9, 4'd10, 4'd11, 4'd12
  };

  // Positions covered by parity group i: one-based index has bit i set.
  function automatic logic [CODE_W-1:0] group_mask(input int i);
    logic [CODE_W-1:0] m;
    m = '0;
    for (int k = 0; k < CODE_W; k++) begin
      m[k] = (((k + 1) >> i) & 1) != 0;
    end
    return m;
  endfunction

  // Least r with 2^r >= d + r + 1, for d data bits.
  function automatic logic [PCNT_W-1:0] parity_for_data(input logic [LEN_W-1:0] d);
    logic [PCNT_W-1:0] r;
    if (d == 4'd0) begin
      r = 3'd0;
    end else if (d == 4'd1) begin
      r = 3'd2;
    end else if (d <= 4'd4) begin
      r = 3'd3;
    end else begin
      r = 3'd4;
    end
    return r;
  endfunction

  // Least r with 2^r >= n + 1, for a codeword of n positions.
  function automatic logic [PCNT_W-1:0] parity_for_length(input logic [LEN_W-1:0] n);
    logic [PCNT_W-1:0] r;
    if (n == 4'd0) begin
      r = 3'd0;
    end else if (n == 4'd1) begin
      r = 3'd1;
    end else if (n <= 4'd3) begin
      r = 3'd2;
    end else if (n <= 4'd7) begin
      r = 3'd3;
    end else begin
      r = 3'd4;
    end
    return r;
  endfunction

endpackage

// ===== sv/hec_core.sv =====
// Combinational encode and check-and-correct datapath of the Hamming byte coder.
// Depends on hec_pkg for widths, the data position table and group masks.
`timescale 1ns / 1ps

module hec_core #(
  parameter int DATA_BITS = hec_pkg::DATA_BITS_DEF
) (
  input  hec_pkg::opcode_t             op,
  input  hec_pkg::parity_mode_t        mode,
  input  logic [hec_pkg::BYTE_W-1:0]   data,
  input  logic [hec_pkg::CODE_W-1:0]   cw_in,
  input  logic [hec_pkg::LEN_W-1:0]    len_in,
  output hec_pkg::result_t             res
);
  import hec_pkg::*;

  logic [BYTE_W-1:0] data_m;
  logic [LEN_W-1:0]  enc_d;
  logic [PCNT_W-1:0] enc_r;
  logic [CODE_W-1:0] enc_raw;
  logic [CODE_W-1:0] enc_cw;
  logic [PCNT_W-1:0] chk_r;
  logic [CODE_W-1:0] used;
  logic [SYN_W-1:0]  syn;
  logic [CODE_W-1:0] cor;
  logic [BYTE_W-1:0] chk_data;
  logic              inv;

  always_comb begin
    // Even mode sets a parity bit on an odd group count; odd mode on an even one.
    inv = (mode == PAR_ODD);

    // Encode: size the code to the highest set data bit.
    data_m = '0;
    for (int j = 0; j < BYTE_W; j++) begin
      if (j < DATA_BITS) data_m[j] = data[j];
    end
    enc_d = '0;
    for (int j = 0; j < BYTE_W; j++) begin
      if (data_m[j]) enc_d = LEN_W'(j + 1);
    end
    enc_r = parity_for_data(enc_d);
    enc_raw = '0;
    for (int j = 0; j < BYTE_W; j++) begin
      enc_raw[DATA_POS[j] - 4'd1] = data_m[j];
    end
    // Data bits above the top set bit are zero, so groups need no length mask.
    enc_cw = enc_raw;
    for (int i = 0; i < SYN_W; i++) begin
      if (PCNT_W'(i) < enc_r) enc_cw[(1 << i) - 1] = (^(enc_raw & group_mask(i))) ^ inv;
    end

    // Check: syndrome over the used positions, then correct a single bit.
    chk_r = parity_for_length(len_in);
    for (int k = 0; k < CODE_W; k++) begin
      used[k] = k < int'(len_in);
    end
    for (int i = 0; i < SYN_W; i++) begin
      syn[i] = (PCNT_W'(i) < chk_r) && (((^(cw_in & used & group_mask(i))) ^ inv) != 1'b0);
    end
    cor = cw_in;
    if (syn != '0 && syn <= SYN_W'(CODE_W)) begin
      cor[syn - 4'd1] = ~cw_in[syn - 4'd1];
    end
    chk_data = '0;
    for (int j = 0; j < BYTE_W; j++) begin
      if (j < DATA_BITS) chk_data[j] = cor[DATA_POS[j] - 4'd1];
    end

    if (op == OP_ENCODE) begin
      res.codeword       = enc_cw;
      res.code_length    = enc_d + LEN_W'(enc_r);
      res.parity_count   = enc_r;
      res.error_found    = 1'b0;
      res.error_position = '0;
      res.data           = data_m;
    end else begin
      res.codeword       = cor;
      res.code_length    = len_in;
      res.parity_count   = chk_r;
      res.error_found    = (syn != '0);
      res.error_position = syn;
      res.data           = chk_data;
    end
  end

endmodule

// ===== sv/hamming_encode_correct_byte.sv =====
// Top level of the Hamming byte coder: input register, datapath, result register.
// Depends on hec_pkg and hec_core.
`timescale 1ns / 1ps

// Hamming single-error-correcting coder for one byte. A command beat is taken
// on every clock edge where start is high; busy never rises, so one beat per
// cycle is sustained. Each command passes the input register, then its result
// from the combinational datapath is held in the result register; that result
// is shown on the out_ ports for a single cycle marked by out_valid. The
// receiver cannot hold results off, so it must take every out_valid beat.
// Opcode OP_ENCODE sizes the code to the byte's highest set bit and returns
// the codeword with its length and parity count; OP_CHECK recomputes the
// parity groups over the given length, reports the syndrome, flips the
// addressed bit when it lies inside the 12-bit codeword and extracts the data.
// The parity sense (even after reset) is set through the cfg_ port, which is
// always ready; write it only while no command is in flight.
module hamming_encode_correct_byte #(
  parameter int DATA_BITS = hec_pkg::DATA_BITS_DEF  // data bits used, 1 to 8
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // Command channel.
  input  logic                         start,
  output logic                         busy,
  input  logic                         in_opcode,
  input  logic [hec_pkg::BYTE_W-1:0]   in_data_byte,
  input  logic [hec_pkg::CODE_W-1:0]   in_codeword_in,
  input  logic [hec_pkg::LEN_W-1:0]    in_code_length_in,
  // Result channel.
  output logic                         out_valid,
  output logic [hec_pkg::CODE_W-1:0]   out_codeword_out,
  output logic [hec_pkg::LEN_W-1:0]    out_code_length,
  output logic [hec_pkg::PCNT_W-1:0]   out_parity_count,
  output logic                         out_error_found,
  output logic [hec_pkg::SYN_W-1:0]    out_error_position,
  output logic [hec_pkg::BYTE_W-1:0]   out_data_out,
  // Configuration channel.
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic                         cfg_parity_mode
);
  import hec_pkg::*;

  // Control state.
  logic         in_valid_r;
  logic         out_valid_r;
  parity_mode_t mode_r;
  parity_mode_t mode_nxt;

  // Input register payload.
  opcode_t           op_r;
  logic [BYTE_W-1:0] data_r;
  logic [CODE_W-1:0] cw_r;
  logic [LEN_W-1:0]  len_r;

  // Result register payload.
  result_t res;
  result_t res_r;

  logic accept;

  // The pipeline never backs up, so the command side is always open.
  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  always_comb begin
    mode_nxt = mode_r;
    if (cfg_valid && cfg_ready) begin
      mode_nxt = parity_mode_t'(cfg_parity_mode);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      mode_r      <= PAR_EVEN;
    end else begin
      in_valid_r  <= accept;
      out_valid_r <= in_valid_r;
      mode_r      <= mode_nxt;
    end
  end

  // Payload registers capture every cycle a beat moves; they need no reset.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r   <= opcode_t'(in_opcode);
      data_r <= in_data_byte;
      cw_r   <= in_codeword_in;
      len_r  <= in_code_length_in;
    end
    if (in_valid_r) begin
      res_r <= res;
    end
  end

  hec_core #(
    .DATA_BITS (DATA_BITS)
  ) u_hec_core (
    .op     (op_r),
    .mode   (mode_r),
    .data   (data_r),
    .cw_in  (cw_r),
    .len_in (len_r),
    .res    (res)
  );

  assign out_valid          = out_valid_r;
  assign out_codeword_out   = res_r.codeword;
  assign out_code_length    = res_r.code_length;
  assign out_parity_count   = res_r.parity_count;
  assign out_error_found    = res_r.error_found;
  assign out_error_position = res_r.error_position;
  assign out_data_out       = res_r.data;

endmodule

// ===== sv/hec_checker.sv =====
// Port-level assertions for the Hamming byte coder and the bind that attaches them.
// Depends on hec_pkg for port widths; binds to hamming_encode_correct_byte.
`timescale 1ns / 1ps

module hec_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         start,
  input logic                         busy,
  input logic                         out_valid,
  input logic [hec_pkg::PCNT_W-1:0]   out_parity_count,
  input logic                         out_error_found,
  input logic [hec_pkg::SYN_W-1:0]    out_error_position
);
  import hec_pkg::*;

  // Every accepted command yields a result once it has passed the input and result registers.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> ##1 out_valid)
    else $error("accepted command produced no result");

  // No result appears without an accepted command that has passed the input and result registers.
  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 2))
    else $error("result without a matching command");

  // The error flag agrees with a nonzero syndrome.
  a_flag_matches: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_error_found == (out_error_position != '0)))
    else $error("error flag disagrees with syndrome");

  // Never more parity bits than the syndrome has bits.
  a_parity_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_parity_count <= PCNT_W'(SYN_W)))
    else $error("parity count out of range");

endmodule

bind hamming_encode_correct_byte hec_checker u_hec_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .start              (start),
  .busy               (busy),
  .out_valid          (out_valid),
  .out_parity_count   (out_parity_count),
  .out_error_found    (out_error_found),
  .out_error_position (out_error_position)
);

// ===== bench/hamming_encode_correct_byte_test.sv =====
// Self-checking bench for the Hamming byte coder: directed corner cases, then random
// encode/check traffic in both parity senses. Depends on hec_pkg and the coder RTL.
`timescale 1ns / 1ps

module hamming_encode_correct_byte_test;
  import hec_pkg::*;

  // A gap of this many cycles with no beat on any channel means the block is hung.
  localparam int STALL_LIMIT = 1000;
  // Idle cycles after the last result drains, so that any stray output is still seen.
  localparam int TAIL_CYCLES = 8;

  logic                clk;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic                in_opcode = 1'b0;
  logic [BYTE_W-1:0]   in_data_byte = '0;
  logic [CODE_W-1:0]   in_codeword_in = '0;
  logic [LEN_W-1:0]    in_code_length_in = '0;
  logic                out_valid;
  logic [CODE_W-1:0]   out_codeword_out;
  logic [LEN_W-1:0]    out_code_length;
  logic [PCNT_W-1:0]   out_parity_count;
  logic                out_error_found;
  logic [SYN_W-1:0]    out_error_position;
  logic [BYTE_W-1:0]   out_data_out;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic                cfg_parity_mode = 1'b0;

  // Our own copy of the parity sense register; it resets to even.
  parity_mode_t parity_sense = PAR_EVEN;
  // Predicted coder outputs, oldest first, one per accepted command beat.
  result_t      results_due[$];
  int           mismatch_count = 0;
  int           quiet_cycles = 0;
  // When set, the command side sends a beat on every cycle it can.
  bit           steady_feed = 1'b0;

  hamming_encode_correct_byte u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_opcode          (in_opcode),
    .in_data_byte       (in_data_byte),
    .in_codeword_in     (in_codeword_in),
    .in_code_length_in  (in_code_length_in),
    .out_valid          (out_valid),
    .out_codeword_out   (out_codeword_out),
    .out_code_length    (out_code_length),
    .out_parity_count   (out_parity_count),
    .out_error_found    (out_error_found),
    .out_error_position (out_error_position),
    .out_data_out       (out_data_out),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_parity_mode    (cfg_parity_mode)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // ---------------------------------------------------------------------------
  // Prediction. Positions are one-based; bit p-1 of a word holds position p. The
  // word is 15 positions wide so that lengths past twelve read zeros, as they
  // must when a check is given a length longer than the codeword port.
  // ---------------------------------------------------------------------------

  // Exclusive-or of the used positions whose index has bit grp set.
  function automatic bit group_ones(input logic [14:0] word, input int used, input int grp);
    bit acc;
    int p;
    acc = 1'b0;
    for (p = 1; p <= used && p <= 15; p++) begin
      if (((p >> grp) & 1) != 0) acc ^= word[p-1];
    end
    return acc;
  endfunction

  function automatic result_t hamming_code_of(input opcode_t op,
                                              input logic [BYTE_W-1:0] data_val,
                                              input logic [CODE_W-1:0] cw_val,
                                              input logic [LEN_W-1:0]  len_val,
                                              input parity_mode_t sense);
    result_t res;
    logic [14:0] word;
    int nbits, npar, used, i, j, p, syn;
    bit flag;
    res = '0;
    word = '0;
    npar = 0;
    syn = 0;
    if (op == OP_ENCODE) begin
      // Size the code to the highest set data bit.
      nbits = 0;
      for (i = 0; i < BYTE_W; i++) begin
        if (data_val[i]) nbits = i + 1;
      end
      while ((1 << npar) < nbits + npar + 1) npar++;
      used = nbits + npar;
      j = 0;
      for (p = 1; p <= used; p++) begin
        if ((p & (p - 1)) != 0) begin
          word[p-1] = data_val[j];
          j++;
        end
      end
      // Parity bit 2^i lies only in its own group, so the order of filling is free.
      for (i = 0; i < npar; i++) begin
        flag = group_ones(word, used, i) ^ (sense == PAR_ODD);
        if (flag) word[(1 << i) - 1] = 1'b1;
      end
      res.data = data_val;
    end else begin
      word[CODE_W-1:0] = cw_val;
      used = len_val;
      while ((1 << npar) < used + 1) npar++;
      for (i = 0; i < npar; i++) begin
        flag = group_ones(word, used, i) ^ (sense == PAR_ODD);
        if (flag) syn |= 1 << i;
      end
      if (syn != 0) begin
        res.error_found = 1'b1;
        // A syndrome that points past the codeword port is reported but flips nothing.
        if (syn <= CODE_W) word[syn-1] = ~word[syn-1];
      end
      // The data sits at the first non-power-of-two positions, whatever the length.
      j = 0;
      for (p = 1; p <= 15 && j < BYTE_W; p++) begin
        if ((p & (p - 1)) != 0) begin
          res.data[j] = word[p-1];
          j++;
        end
      end
    end
    res.codeword       = word[CODE_W-1:0];
    res.code_length    = LEN_W'(used);
    res.parity_count   = PCNT_W'(npar);
    res.error_position = SYN_W'(syn);
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Command side. Every task starts and ends right after a rising edge, so each
  // input gets at most one nonblocking assignment per time step.
  // ---------------------------------------------------------------------------

  // Sends one command beat, with a random gap ahead of it unless the feed is
  // steady, and records its predicted result once the beat is taken.
  task automatic issue_command(input opcode_t op, input logic [BYTE_W-1:0] data_val,
                               input logic [CODE_W-1:0] cw_val,
                               input logic [LEN_W-1:0] len_val);
    while (!steady_feed && $urandom_range(99) < 36) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start             <= 1'b1;
    in_opcode         <= op;
    in_data_byte      <= data_val;
    in_codeword_in    <= cw_val;
    in_code_length_in <= len_val;
    do @(posedge clk); while (busy);
    results_due.push_back(hamming_code_of(op, data_val, cw_val, len_val, parity_sense));
  endtask

  // Holds the command side off until every predicted result has come back.
  task automatic settle_all();
    start <= 1'b0;
    @(posedge clk);
    while (results_due.size() != 0) @(posedge clk);
  endtask

  // Each command causes exactly one result, so an empty queue means the block is idle.
  task automatic write_parity_mode(input parity_mode_t sense);
    settle_all();
    while (!steady_feed && $urandom_range(99) < 36) @(posedge clk);
    cfg_valid       <= 1'b1;
    cfg_parity_mode <= sense;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid    <= 1'b0;
    parity_sense = sense;
  endtask

  // ---------------------------------------------------------------------------
  // Result side. The receiver cannot stall, so every out_valid beat is checked
  // on the edge that ends it, against the oldest prediction.
  // ---------------------------------------------------------------------------

  task automatic report_field(input string field, input int want, input int seen);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("[%0t] %s mismatch: expected %0d, got %0d", $realtime, field, want, seen);
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_valid) begin
      if (results_due.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("[%0t] result beat with nothing outstanding: codeword %0h",
                   $realtime, out_codeword_out);
      end else begin
        want = results_due.pop_front();
        if (out_codeword_out !== want.codeword)
          report_field("codeword_out", want.codeword, out_codeword_out);
        if (out_code_length !== want.code_length)
          report_field("code_length", want.code_length, out_code_length);
        if (out_parity_count !== want.parity_count)
          report_field("parity_count", want.parity_count, out_parity_count);
        if (out_error_found !== want.error_found)
          report_field("error_found", want.error_found, out_error_found);
        if (out_error_position !== want.error_position)
          report_field("error_position", want.error_position, out_error_position);
        if (out_data_out !== want.data)
          report_field("data_out", want.data, out_data_out);
      end
    end
  end

  // Watchdog: any beat on any channel counts as progress.
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // No register write yet: the coder must already be in even parity.
  task automatic test_reset_sense();
    result_t clean;
    clean = hamming_code_of(OP_ENCODE, 8'hFF, '0, '0, parity_sense);
    issue_command(OP_ENCODE, 8'h00, CODE_W'($urandom), LEN_W'($urandom));
    issue_command(OP_ENCODE, 8'h01, CODE_W'($urandom), LEN_W'($urandom));
    issue_command(OP_ENCODE, 8'hFF, CODE_W'($urandom), LEN_W'($urandom));
    issue_command(OP_CHECK, BYTE_W'($urandom), clean.codeword, clean.code_length);
  endtask

  // Bytes whose top set bit lands at each end of the three- and four-parity code sizes, plus alternating patterns.
  task automatic test_encode_sizes();
    issue_command(OP_ENCODE, 8'h02, CODE_W'($urandom), LEN_W'($urandom));
    issue_command(OP_ENCODE, 8'h0F, CODE_W'($urandom), LEN_W'($urandom));
    issue_command(OP_ENCODE, 8'h10, CODE_W'($urandom), LEN_W'($urandom));
    issue_command(OP_ENCODE, 8'h80, CODE_W'($urandom), LEN_W'($urandom));
    issue_command(OP_ENCODE, 8'hA5, CODE_W'($urandom), LEN_W'($urandom));
    issue_command(OP_ENCODE, 8'h5A, CODE_W'($urandom), LEN_W'($urandom));
  endtask

  // Even-parity checks: a flipped data bit, a flipped parity bit, an empty code,
  // a length past the codeword port, and set bits lying past the given length.
  task automatic test_even_checks();
    result_t clean;
    clean = hamming_code_of(OP_ENCODE, 8'hA5, '0, '0, parity_sense);
    issue_command(OP_CHECK, BYTE_W'($urandom), clean.codeword ^ 12'h040, clean.code_length);
    issue_command(OP_CHECK, BYTE_W'($urandom), clean.codeword ^ 12'h008, clean.code_length);
    issue_command(OP_CHECK, BYTE_W'($urandom), 12'hFFF, 4'd0);
    issue_command(OP_CHECK, BYTE_W'($urandom), 12'hFFF, 4'd15);
    issue_command(OP_CHECK, BYTE_W'($urandom), 12'h060, 4'd5);
  endtask

  // Odd parity: an all-zero word fails every group, so the syndrome runs to its
  // top value. At length 12 and 13 that points past the port and flips nothing;
  // at length 5 it points at position 7, past the length but still flipped.
  task automatic test_odd_parity();
    result_t clean;
    write_parity_mode(PAR_ODD);
    clean = hamming_code_of(OP_ENCODE, 8'h3C, '0, '0, parity_sense);
    issue_command(OP_ENCODE, 8'h00, CODE_W'($urandom), LEN_W'($urandom));
    issue_command(OP_ENCODE, 8'h01, CODE_W'($urandom), LEN_W'($urandom));
    issue_command(OP_CHECK, BYTE_W'($urandom), 12'h000, 4'd13);
    issue_command(OP_CHECK, BYTE_W'($urandom), 12'h000, 4'd12);
    issue_command(OP_CHECK, BYTE_W'($urandom), 12'h000, 4'd5);
    issue_command(OP_CHECK, BYTE_W'($urandom), 12'h001, 4'd1);
    issue_command(OP_CHECK, BYTE_W'($urandom), clean.codeword ^ 12'h200, clean.code_length);
  endtask

  // Mostly well-formed traffic: fresh encodes, and checks of properly encoded
  // words carrying no error or one flipped bit. The rest is noise: arbitrary
  // words and lengths, or two flipped bits. Now and then the sender waits for
  // the block to drain completely.
  task automatic test_random_traffic(input int count);
    result_t clean;
    logic [BYTE_W-1:0] data_val;
    logic [CODE_W-1:0] cw_val;
    int pick, pos;
    repeat (count) begin
      pick     = $urandom_range(99);
      data_val = BYTE_W'($urandom_range(255)) >> $urandom_range(BYTE_W - 1);
      if (pick < 45) begin
        issue_command(OP_ENCODE, data_val, CODE_W'($urandom), LEN_W'($urandom));
      end else begin
        clean  = hamming_code_of(OP_ENCODE, data_val, '0, '0, parity_sense);
        cw_val = clean.codeword;
        if (pick < 85) begin
          if (clean.code_length != 0 && $urandom_range(3) != 0) begin
            pos = $urandom_range(clean.code_length, 1);
            cw_val[pos-1] = ~cw_val[pos-1];
          end
          issue_command(OP_CHECK, BYTE_W'($urandom), cw_val, clean.code_length);
        end else if ($urandom_range(1) == 0) begin
          issue_command(OP_CHECK, BYTE_W'($urandom), CODE_W'($urandom), LEN_W'($urandom));
        end else begin
          cw_val[$urandom_range(CODE_W - 1)] ^= 1'b1;
          cw_val[$urandom_range(CODE_W - 1)] ^= 1'b1;
          issue_command(OP_CHECK, BYTE_W'($urandom), cw_val, clean.code_length);
        end
      end
      if ($urandom_range(49) == 0) settle_all();
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_sense();
    test_encode_sizes();
    test_even_checks();
    test_odd_parity();

    write_parity_mode(PAR_EVEN);
    test_random_traffic(130);

    // Back-to-back beats for a whole phase, in odd parity.
    write_parity_mode(PAR_ODD);
    steady_feed = 1'b1;
    test_random_traffic(130);
    steady_feed = 1'b0;

    write_parity_mode(PAR_EVEN);
    test_random_traffic(140);

    settle_all();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && results_due.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
